// ----- src/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and codes for the cartridge bank mapper and IRQ unit.
// ----------------------------------------------------------------------------
package cbm_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req_e;

    localparam logic [1:0] SRC_MAPPER = 2'd0;
    localparam logic [1:0] SRC_WRAM   = 2'd1;
    localparam logic [1:0] SRC_NONE   = 2'd2;

    localparam logic [1:0] CFG_REGION_ASIA  = 2'd0;
    localparam logic [1:0] CFG_HAS_WORK_RAM = 2'd1;
    localparam logic [1:0] CFG_CHR_IS_512K  = 2'd2;

    localparam logic [6:0] HELD_E000_RESET = 7'd31;
    localparam logic [4:0] WRAM_BANK_FIXED = 5'h1F;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] read_source;
        logic       irq_line;
        logic [6:0] prg_slot_8000;
        logic [6:0] prg_slot_a000;
        logic [6:0] prg_slot_c000;
        logic [6:0] prg_slot_e000;
        logic [4:0] wram_bank;
        logic [1:0] mirror_mode;
        logic       chr_write_valid;
        logic [2:0] chr_slot;
        logic [9:0] chr_bank;
    } t_out_item;

    typedef struct packed {
        logic region_asia;
        logic has_work_ram;
        logic chr_is_512k;
    } t_cfg;

    typedef struct packed {
        logic [7:0]      control;
        logic [3:0][4:0] bank_regs;
        logic [7:0]      outer;
        logic            irq_pending;
        logic [1:0]      mirror;
    } t_map_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] read_source;
        logic       chr_valid;
        logic [2:0] chr_slot;
        logic [9:0] chr_bank;
    } t_bus_resp;

    typedef struct packed {
        logic [6:0] slot_8000;
        logic [6:0] slot_a000;
        logic [6:0] slot_c000;
        logic [6:0] slot_e000;
        logic [4:0] wram_bank;
    } t_prg_map;

endpackage

// ----- src/cbm_regs.sv -----
// ----------------------------------------------------------------------------
// cbm_regs
// Bus decode, mapper registers and the 16-bit up/down IRQ counter.
// ----------------------------------------------------------------------------
module cbm_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  cbm_pkg::t_in_item   i_item,
    input  cbm_pkg::t_cfg       i_cfg,
    output cbm_pkg::t_map_state o_next,
    output cbm_pkg::t_bus_resp  o_resp
);

    logic [7:0]      r_control, n_control;
    logic [3:0][4:0] r_bank_regs, n_bank_regs;
    logic [7:0]      r_outer, n_outer;
    logic [7:0]      r_scratch, n_scratch;
    logic            r_irq_en, n_irq_en;
    logic [15:0]     r_irq_cnt, n_irq_cnt;
    logic            r_irq_down, n_irq_down;
    logic            r_irq_pend, n_irq_pend;
    logic [1:0]      r_mirror, n_mirror;

    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  ctrl_diff;
    logic [15:0] cnt_step;
    cbm_pkg::t_bus_resp resp;

    assign a         = i_item.bus_address;
    assign d         = i_item.bus_data;
    assign ctrl_diff = d ^ r_control;
    assign cnt_step  = r_irq_down ? (r_irq_cnt - 16'd1) : (r_irq_cnt + 16'd1);

    always_comb begin
        n_control   = r_control;
        n_bank_regs = r_bank_regs;
        n_outer     = r_outer;
        n_scratch   = r_scratch;
        n_irq_en    = r_irq_en;
        n_irq_cnt   = r_irq_cnt;
        n_irq_down  = r_irq_down;
        n_irq_pend  = r_irq_pend;
        n_mirror    = r_mirror;
        resp        = '0;
        resp.read_source = cbm_pkg::SRC_NONE;
        unique case (cbm_pkg::t_req_e'(i_item.req_type))
            cbm_pkg::REQ_WRITE: begin
                priority if (a[15:8] == 8'h51) begin
                    n_scratch = d;
                end else if (a == 16'hB000 || a == 16'hB0FF || a == 16'hB100) begin
                    n_outer = d;
                end else if (a[15:12] == 4'h8) begin
                    unique case (a[9:8])
                        2'd0: n_outer = d;
                        2'd1: begin
                            n_control = d;
                            if (ctrl_diff[7:6] != 2'b00) begin
                                n_irq_down = d[6];
                            end
                            if (ctrl_diff[1:0] != 2'b00) begin
                                n_mirror = d[1:0];
                            end
                        end
                        2'd2: begin
                            if (a[0]) begin
                                n_irq_cnt = {d, r_irq_cnt[7:0]};
                                n_irq_en  = r_control[7];
                            end else begin
                                n_irq_cnt = {r_irq_cnt[15:8], d};
                            end
                            n_irq_pend = 1'b0;
                        end
                        default: begin
                            if (!a[4]) begin
                                n_bank_regs[a[1:0]] = d[4:0];
                            end else if (!a[3]) begin
                                if (i_cfg.chr_is_512k) begin
                                    if (a[2:1] == 2'b00 || a[2:1] == 2'b11) begin
                                        resp.chr_valid = 1'b1;
                                        resp.chr_slot  = {1'b0, a[1:0]};
                                        resp.chr_bank  = {2'b00, d};
                                    end
                                end else begin
                                    resp.chr_valid = 1'b1;
                                    resp.chr_slot  = a[2:0];
                                    resp.chr_bank  = {r_outer[5:4], d};
                                end
                            end
                        end
                    endcase
                end else begin
                end
            end
            cbm_pkg::REQ_READ: begin
                priority if (a == 16'h5000) begin
                    resp.read_source = cbm_pkg::SRC_MAPPER;
                    resp.read_data   = i_cfg.region_asia ? 8'hFF : 8'h00;
                end else if (a[15:8] == 8'h51) begin
                    resp.read_source = cbm_pkg::SRC_MAPPER;
                    resp.read_data   = r_scratch;
                end else if (!i_cfg.has_work_ram && a[15:13] == 3'b011) begin
                    if (r_control[5]) begin
                        resp.read_source = cbm_pkg::SRC_WRAM;
                    end else begin
                        resp.read_source = cbm_pkg::SRC_MAPPER;
                        resp.read_data   = a[15:8];
                    end
                end else begin
                end
            end
            cbm_pkg::REQ_TICK: begin
                if (r_irq_en && r_irq_cnt != 16'd0) begin
                    n_irq_cnt = cnt_step;
                    if (cnt_step == 16'd0) begin
                        n_irq_en   = 1'b0;
                        n_irq_pend = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control   <= '0;
            r_bank_regs <= '0;
            r_outer     <= '0;
            r_scratch   <= '0;
            r_irq_en    <= 1'b0;
            r_irq_cnt   <= '0;
            r_irq_down  <= 1'b0;
            r_irq_pend  <= 1'b0;
            r_mirror    <= '0;
        end else if (i_advance) begin
            r_control   <= n_control;
            r_bank_regs <= n_bank_regs;
            r_outer     <= n_outer;
            r_scratch   <= n_scratch;
            r_irq_en    <= n_irq_en;
            r_irq_cnt   <= n_irq_cnt;
            r_irq_down  <= n_irq_down;
            r_irq_pend  <= n_irq_pend;
            r_mirror    <= n_mirror;
        end
    end

    assign o_next.control     = n_control;
    assign o_next.bank_regs   = n_bank_regs;
    assign o_next.outer       = n_outer;
    assign o_next.irq_pending = n_irq_pend;
    assign o_next.mirror      = n_mirror;
    assign o_resp             = resp;

endmodule

// ----- src/cbm_bank_map.sv -----
// ----------------------------------------------------------------------------
// cbm_bank_map
// Program slot and work-RAM bank map, with the held 0xE000 slot.
// ----------------------------------------------------------------------------
module cbm_bank_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  cbm_pkg::t_map_state i_state,
    output cbm_pkg::t_prg_map   o_map
);

    logic [6:0] r_held_e000, n_held_e000;
    logic [6:0] lo_base;
    logic [6:0] hi_base;
    cbm_pkg::t_prg_map map;

    assign lo_base = {i_state.outer[5:0], 1'b0};
    assign hi_base = {i_state.outer[5:4], 4'hF, 1'b0};

    always_comb begin
        if (i_state.control[4]) begin
            map.slot_8000 = {2'b00, i_state.bank_regs[0]};
            map.slot_a000 = {2'b00, i_state.bank_regs[1]};
            map.slot_c000 = {2'b00, i_state.bank_regs[2]};
            map.slot_e000 = r_held_e000;
            map.wram_bank = cbm_pkg::WRAM_BANK_FIXED;
        end else begin
            map.slot_8000 = lo_base;
            map.slot_a000 = lo_base | 7'd1;
            map.slot_c000 = hi_base;
            map.slot_e000 = hi_base | 7'd1;
            map.wram_bank = i_state.bank_regs[3];
        end
        n_held_e000 = map.slot_e000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_e000 <= cbm_pkg::HELD_E000_RESET;
        end else if (i_advance) begin
            r_held_e000 <= n_held_e000;
        end
    end

    assign o_map = map;

endmodule

// ----- src/cartridge_bank_mapper_irq_unit.sv -----
// Each item passes the input register, then the result register; a stalled output
// holds it in the input register until the result register can take it.
// Throughput: one item per cycle while the output is not stalled; the decode and
// counter update between the two registers are combinational.
// Reset: synchronous active low; mapper state clears, held 0xE000 slot is 31,
// region_asia and has_work_ram set, chr_is_512k clear.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_unit
// Cartridge bank mapper with an IRQ counter driven by tick requests, top level.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cbm_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic               i_cfg_data
);

    logic               r_in_valid;
    cbm_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    cbm_pkg::t_out_item r_out_item, n_out_item;
    cbm_pkg::t_cfg      r_cfg;
    logic               advance;
    logic               in_fire;

    cbm_pkg::t_map_state next_state;
    cbm_pkg::t_bus_resp  resp;
    cbm_pkg::t_prg_map   prg_map;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    cbm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (r_cfg),
        .o_next    (next_state),
        .o_resp    (resp)
    );

    cbm_bank_map u_bank_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_state   (next_state),
        .o_map     (prg_map)
    );

    always_comb begin
        n_out_item.read_data       = resp.read_data;
        n_out_item.read_source     = resp.read_source;
        n_out_item.irq_line        = next_state.irq_pending;
        n_out_item.prg_slot_8000   = prg_map.slot_8000;
        n_out_item.prg_slot_a000   = prg_map.slot_a000;
        n_out_item.prg_slot_c000   = prg_map.slot_c000;
        n_out_item.prg_slot_e000   = prg_map.slot_e000;
        n_out_item.wram_bank       = prg_map.wram_bank;
        n_out_item.mirror_mode     = next_state.mirror;
        n_out_item.chr_write_valid = resp.chr_valid;
        n_out_item.chr_slot        = resp.chr_slot;
        n_out_item.chr_bank        = resp.chr_bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_asia  <= 1'b1;
            r_cfg.has_work_ram <= 1'b1;
            r_cfg.chr_is_512k  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cbm_pkg::CFG_REGION_ASIA:  r_cfg.region_asia  <= i_cfg_data;
                cbm_pkg::CFG_HAS_WORK_RAM: r_cfg.has_work_ram <= i_cfg_data;
                cbm_pkg::CFG_CHR_IS_512K:  r_cfg.chr_is_512k  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
